// File: sv/ucd_pkg.sv
// ----------------------------------------------------------------------------
// ucd_pkg: shared types and constants of the UART LED command decoder
// Character codes, match flag layout, response codes and the fixed-point
// reciprocal used to divide the scaled duty product by one hundred.
// ----------------------------------------------------------------------------
package ucd_pkg;

    localparam int LINE_DEPTH_DEF = 64;

    localparam logic [7:0] CH_BANG    = 8'd33;   // '!'
    localparam logic [7:0] CH_PERCENT = 8'd37;   // '%'
    localparam logic [7:0] CH_ZERO    = 8'd48;   // '0'
    localparam logic [7:0] CH_NINE    = 8'd57;   // '9'
    localparam logic [7:0] CH_NUL     = 8'd0;

    localparam logic [15:0] PERIOD_TOP_RESET = 16'd999;
    localparam logic [6:0]  PERCENT_RESET    = 7'd100;
    localparam logic [6:0]  PERCENT_MAX      = 7'd100;
    localparam logic [6:0]  DIGIT_SAT        = 7'd101;

    // floor(x / 100) == (x * RECIP_MUL) >> RECIP_SHIFT for x < 2^23
    localparam int          PROD_W      = 23;
    localparam int          RECIP_W     = 24;
    localparam int          RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 24'd10737419;

    // match flag bit positions
    localparam int F_ON     = 0;
    localparam int F_OFF    = 1;
    localparam int F_STATUS = 2;
    localparam int F_PWM    = 3;
    localparam logic [3:0] FLAGS_ALL = 4'b1111;

    typedef enum logic [1:0] {
        PH_DIGITS = 2'd0,
        PH_DONE   = 2'd1,
        PH_BAD    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        RSP_LED_ON     = 3'd0,
        RSP_LED_OFF    = 3'd1,
        RSP_PWM_OK     = 3'd2,
        RSP_PWM_ERR    = 3'd3,
        RSP_STATUS_ON  = 3'd4,
        RSP_STATUS_OFF = 3'd5,
        RSP_UNKNOWN    = 3'd6
    } rsp_t;

    // parser verdict for the line closed by '!'
    typedef struct packed {
        logic       line_end;
        logic [3:0] flags;
        logic       pwm_ok;
    } cmd_t;

    function automatic logic [7:0] on_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "O";
            default: ch = "N";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] off_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "O";
            default: ch = "F";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] status_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "S";
            3'd1:    ch = "t";
            3'd2:    ch = "a";
            3'd3:    ch = "t";
            3'd4:    ch = "u";
            default: ch = "s";
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] pwm_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "P";
            3'd1:    ch = "W";
            3'd2:    ch = "M";
            default: ch = ":";
        endcase
        return ch;
    endfunction

endpackage

// File: sv/ucd_parser.sv
// ----------------------------------------------------------------------------
// ucd_parser: on-the-fly command line matcher
// Tracks the line position, the still-possible commands and the PWM number
// one byte per step, and reports the verdict when '!' closes the line.
// ----------------------------------------------------------------------------
module ucd_parser
    import ucd_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output cmd_t       cmd,
    output logic [6:0] digit_value
);

    localparam int POS_W = $clog2(LINE_DEPTH);
    localparam logic [POS_W-1:0] POS_FULL = POS_W'(LINE_DEPTH - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       flags_reg, flags_next;
    logic             ended_reg, ended_next;
    phase_t           phase_reg, phase_next;
    logic [6:0]       digit_reg, digit_next;

    logic [3:0] closed_flags;
    logic [3:0] take_flags;
    logic [9:0] acc;
    logic       is_digit;

    // drop every command whose length cannot match the text so far
    always_comb begin
        closed_flags = flags_reg;
        if (pos_reg != POS_W'(2)) closed_flags[F_ON]     = 1'b0;
        if (pos_reg != POS_W'(3)) closed_flags[F_OFF]    = 1'b0;
        if (pos_reg != POS_W'(6)) closed_flags[F_STATUS] = 1'b0;
        if (pos_reg <  POS_W'(4)) closed_flags[F_PWM]    = 1'b0;
    end

    always_comb begin
        take_flags = flags_reg;
        if (pos_reg >= POS_W'(2) || on_char(pos_reg[2:0]) != rx_byte)
            take_flags[F_ON] = 1'b0;
        if (pos_reg >= POS_W'(3) || off_char(pos_reg[2:0]) != rx_byte)
            take_flags[F_OFF] = 1'b0;
        if (pos_reg >= POS_W'(6) || status_char(pos_reg[2:0]) != rx_byte)
            take_flags[F_STATUS] = 1'b0;
        if (pos_reg < POS_W'(4) && pwm_char(pos_reg[2:0]) != rx_byte)
            take_flags[F_PWM] = 1'b0;
    end

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign acc      = 10'(digit_reg) * 10'd10 + 10'(rx_byte[3:0]);

    always_comb begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        ended_next = ended_reg;
        phase_next = phase_reg;
        digit_next = digit_reg;
        if (step) begin
            if (rx_byte == CH_BANG || pos_reg == POS_FULL) begin
                // close or overflow: restart the line, overflow byte dropped
                pos_next   = '0;
                flags_next = FLAGS_ALL;
                ended_next = 1'b0;
                phase_next = PH_DIGITS;
                digit_next = '0;
            end else begin
                pos_next = pos_reg + POS_W'(1);
                if (!ended_reg) begin
                    if (rx_byte == CH_NUL) begin
                        flags_next = closed_flags;
                        ended_next = 1'b1;
                    end else begin
                        flags_next = take_flags;
                        if (pos_reg >= POS_W'(4) && phase_reg == PH_DIGITS) begin
                            if (is_digit) begin
                                digit_next = (acc > 10'(PERCENT_MAX)) ? DIGIT_SAT : acc[6:0];
                            end else if (rx_byte == CH_PERCENT) begin
                                phase_next = PH_DONE;
                            end else begin
                                phase_next = PH_BAD;
                            end
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            flags_reg <= FLAGS_ALL;
            ended_reg <= 1'b0;
            phase_reg <= PH_DIGITS;
            digit_reg <= '0;
        end else begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            ended_reg <= ended_next;
            phase_reg <= phase_next;
            digit_reg <= digit_next;
        end
    end

    assign cmd.line_end = step && (rx_byte == CH_BANG);
    assign cmd.flags    = ended_reg ? flags_reg : closed_flags;
    assign cmd.pwm_ok   = (phase_reg == PH_DONE) && (digit_reg <= PERCENT_MAX);
    assign digit_value  = digit_reg;

endmodule

// File: sv/ucd_scaler.sv
// ----------------------------------------------------------------------------
// ucd_scaler: duty compare value percent * period_top / 100
// Keeps both candidate products registered every cycle, then divides the
// selected one by one hundred through a reciprocal multiply.
// ----------------------------------------------------------------------------
module ucd_scaler
    import ucd_pkg::*;
(
    input  logic        aclk,
    input  logic [6:0]  digit_value,
    input  logic [6:0]  percent,
    input  logic [15:0] period_top,
    input  logic        sel_digit,
    output logic [15:0] scaled
);

    logic [PROD_W-1:0]         prod_dig_reg, prod_pct_reg;
    logic [PROD_W-1:0]         prod_sel;
    logic [PROD_W+RECIP_W-1:0] quot_full;

    // operands are registered and settle before the '!' that uses them
    always_ff @(posedge aclk) begin
        prod_dig_reg <= PROD_W'(digit_value) * PROD_W'(period_top);
        prod_pct_reg <= PROD_W'(percent) * PROD_W'(period_top);
    end

    assign prod_sel  = sel_digit ? prod_dig_reg : prod_pct_reg;
    assign quot_full = (PROD_W+RECIP_W)'(prod_sel) * (PROD_W+RECIP_W)'(RECIP_MUL);
    assign scaled    = quot_full[RECIP_SHIFT+15:RECIP_SHIFT];

endmodule

// File: sv/uart_led_command_decoder.sv
// ----------------------------------------------------------------------------
// uart_led_command_decoder: LED command parser for a received UART stream
// Matches ON, OFF, Status and PWM:<n>% lines closed by '!' and keeps the
// LED state, stored percent and PWM compare value.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one received byte per beat in s_tdata[7:0].
//   m_ channel: one beat per '!' byte; all other bytes give no beat.
//   cfg channel: writes period_top, always ready; write only while idle.
//   Each byte is parsed straight out of the input register once it can
//   advance; the response beat for a '!' is registered and shown on m_
//   from the edge at which the '!' is parsed. One byte is accepted every
//   cycle while m_ is not stalled.
//   When the receiver stalls with a response pending, one more byte is
//   held in the input register and s_tready drops until m_tready returns.
//   Reset clears the line, turns the LED off, sets the percent to 100,
//   the compare value to 0 and period_top to 999. No clearing pass.
//   The line holds LINE_DEPTH-1 characters; the byte that overflows it is
//   dropped and the line restarts.
// ----------------------------------------------------------------------------
module uart_led_command_decoder
    import ucd_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [2:0] response_code, [3] led_is_on,
                                    // [10:4] saved_percent, [26:11] duty_compare
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data    // period_top
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        m_valid_reg, m_valid_next;
    rsp_t        code_reg, code_next;
    logic        led_reg, led_next;
    logic [6:0]  percent_reg, percent_next;
    logic [15:0] compare_reg, compare_next;
    logic [15:0] period_top_reg;

    logic        advance;
    cmd_t        cmd;
    logic [6:0]  digit_value;
    logic        sel_digit;
    logic [15:0] scaled;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    ucd_parser #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (advance),
        .rx_byte    (in_byte_reg),
        .cmd        (cmd),
        .digit_value(digit_value)
    );

    assign sel_digit = !cmd.flags[F_ON];

    ucd_scaler u_scaler (
        .aclk       (aclk),
        .digit_value(digit_value),
        .percent    (percent_reg),
        .period_top (period_top_reg),
        .sel_digit  (sel_digit),
        .scaled     (scaled)
    );

    // command decode, first match wins
    always_comb begin
        code_next    = code_reg;
        led_next     = led_reg;
        percent_next = percent_reg;
        compare_next = compare_reg;
        if (cmd.line_end) begin
            if (cmd.flags[F_ON]) begin
                led_next     = 1'b1;
                compare_next = scaled;
                code_next    = RSP_LED_ON;
            end else if (cmd.flags[F_OFF]) begin
                led_next     = 1'b0;
                compare_next = '0;
                code_next    = RSP_LED_OFF;
            end else if (cmd.flags[F_PWM]) begin
                if (cmd.pwm_ok) begin
                    percent_next = digit_value;
                    if (led_reg) compare_next = scaled;
                    code_next = RSP_PWM_OK;
                end else begin
                    code_next = RSP_PWM_ERR;
                end
            end else if (cmd.flags[F_STATUS]) begin
                code_next = led_reg ? RSP_STATUS_ON : RSP_STATUS_OFF;
            end else begin
                code_next = RSP_UNKNOWN;
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) in_valid_next = s_tvalid;
        m_valid_next = m_valid_reg;
        if (m_tready) m_valid_next = 1'b0;
        if (cmd.line_end) m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            code_reg       <= RSP_UNKNOWN;
            led_reg        <= 1'b0;
            percent_reg    <= PERCENT_RESET;
            compare_reg    <= '0;
            period_top_reg <= PERIOD_TOP_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            code_reg     <= code_next;
            led_reg      <= led_next;
            percent_reg  <= percent_next;
            compare_reg  <= compare_next;
            if (cfg_valid) period_top_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) in_byte_reg <= s_tdata;
    end

    // state only moves on '!', so the live state is the pending response
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, compare_reg, percent_reg, led_reg, code_reg};

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the UART LED command decoder
// Streams command lines (ON, OFF, Status, PWM:<n>%) and garbage into the
// decoder, predicts every response beat from a behavioral copy of the
// parser, and compares each beat field by field under random stalls on
// both sides and across several timer top values.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import ucd_pkg::*;

    localparam int LINE_DEPTH     = LINE_DEPTH_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct packed {
        rsp_t        code;
        logic        led;
        logic [6:0]  pct;
        logic [15:0] duty;
    } reply_t;

    // Behavioral copy of the line parser plus the queue of replies still owed.
    class led_command_tracker;
        reply_t      pending_replies[$];
        int          errors;
        logic [15:0] top;
        int unsigned pos;
        logic [3:0]  flags;
        bit          ended;
        phase_t      phase;
        int unsigned digits;
        bit          led;
        logic [6:0]  pct;
        logic [15:0] duty;
        string       on_txt     = "ON";
        string       off_txt    = "OFF";
        string       status_txt = "Status";
        string       pwm_txt    = "PWM:";

        function new();
            top    = PERIOD_TOP_RESET;
            led    = 1'b0;
            pct    = PERCENT_RESET;
            duty   = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            pos    = 0;
            flags  = FLAGS_ALL;
            ended  = 1'b0;
            phase  = PH_DIGITS;
            digits = 0;
        endfunction

        function logic [15:0] scale(logic [6:0] p);
            int unsigned prod;
            prod = 32'(p);
            prod = prod * top;
            return 16'(prod / 100);
        endfunction

        // drop the commands whose length cannot match a text of length len
        function void close_text(int unsigned len);
            if (len != 2) flags[F_ON] = 1'b0;
            if (len != 3) flags[F_OFF] = 1'b0;
            if (len != 6) flags[F_STATUS] = 1'b0;
            if (len < 4) flags[F_PWM] = 1'b0;
            ended = 1'b1;
        endfunction

        function void take_char(int unsigned p, logic [7:0] c);
            int unsigned v;
            if (p >= 2 || on_txt[p] != c) flags[F_ON] = 1'b0;
            if (p >= 3 || off_txt[p] != c) flags[F_OFF] = 1'b0;
            if (p >= 6 || status_txt[p] != c) flags[F_STATUS] = 1'b0;
            if (p < 4) begin
                if (pwm_txt[p] != c) flags[F_PWM] = 1'b0;
            end else if (phase == PH_DIGITS) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    v = digits * 10 + (c - CH_ZERO);
                    digits = (v > PERCENT_MAX) ? DIGIT_SAT : v;
                end else if (c == CH_PERCENT) begin
                    phase = PH_DONE;
                end else begin
                    phase = PH_BAD;
                end
            end
        endfunction

        function void take_byte(logic [7:0] c);
            reply_t r;
            if (c != CH_BANG) begin
                // a full line restarts and the byte is lost
                if (pos >= LINE_DEPTH - 1) begin
                    restart();
                    return;
                end
                if (!ended) begin
                    if (c == CH_NUL) close_text(pos);
                    else take_char(pos, c);
                end
                pos++;
                return;
            end
            if (!ended) close_text(pos);
            if (flags[F_ON]) begin
                led    = 1'b1;
                duty   = scale(pct);
                r.code = RSP_LED_ON;
            end else if (flags[F_OFF]) begin
                led    = 1'b0;
                duty   = '0;
                r.code = RSP_LED_OFF;
            end else if (flags[F_PWM]) begin
                if (phase == PH_DONE && digits <= PERCENT_MAX) begin
                    pct = 7'(digits);
                    if (led) duty = scale(pct);
                    r.code = RSP_PWM_OK;
                end else begin
                    r.code = RSP_PWM_ERR;
                end
            end else if (flags[F_STATUS]) begin
                r.code = led ? RSP_STATUS_ON : RSP_STATUS_OFF;
            end else begin
                r.code = RSP_UNKNOWN;
            end
            restart();
            r.led  = led;
            r.pct  = pct;
            r.duty = duty;
            pending_replies.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic [31:0] d);
            reply_t want;
            if (pending_replies.size() == 0) begin
                $error("reply beat 0x%h with no command pending", d);
                errors++;
                return;
            end
            want = pending_replies.pop_front();
            compare_field("response_code", 16'(want.code), 16'(d[2:0]));
            compare_field("led_is_on", 16'(want.led), 16'(d[3]));
            compare_field("saved_percent", 16'(want.pct), 16'(d[10:4]));
            compare_field("duty_compare", want.duty, d[26:11]);
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data  = '0;

    led_command_tracker tracker = new();

    int         src_idle   = 0;
    int         sink_idle  = 0;
    int         bytes_sent = 0;
    int         quiet_cycles = 0;
    logic [7:0] line_buf[$];

    uart_led_command_decoder #(
        .LINE_DEPTH(LINE_DEPTH)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #2;
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle);
    end

    // check reply beats first, then feed the accepted byte to the predictor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_reply(m_tdata);
            if (s_tvalid && s_tready) tracker.take_byte(s_tdata);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    // hold the sender until every reply is in and the pipeline is empty
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_replies.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_top(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.top = v;
    endtask

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255)); while (b == CH_BANG);
        return b;
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    task automatic random_line();
        int    kind;
        int    v;
        string num;
        line_buf.delete();
        kind = $urandom_range(99);
        if (kind < 12) begin
            add_text("ON");
        end else if (kind < 24) begin
            add_text("OFF");
        end else if (kind < 36) begin
            add_text("Status");
        end else if (kind < 78) begin
            add_text("PWM:");
            v = $urandom_range(99);
            if (v < 8) num = "";
            else if (v < 70) num = $sformatf("%0d", $urandom_range(100));
            else if (v < 80) num = $sformatf("00%0d", $urandom_range(100));
            else num = $sformatf("%0d", $urandom_range(99999, 101));
            add_text(num);
            if (kind < 72) begin
                add_text("%");
                // trailing text after the percent sign is ignored
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(5, 1)) line_buf.push_back(rand_text_byte());
            end else if (kind < 75) begin
                line_buf.insert($urandom_range(line_buf.size(), 4), rand_text_byte());
                add_text("%");
            end
        end else if (kind < 90) begin
            case ($urandom_range(3))
                0: add_text("ON");
                1: add_text("OFF");
                2: add_text("Status");
                default: add_text("PWM:50%");
            endcase
            v = $urandom_range(line_buf.size());
            if ($urandom_range(1)) begin
                if (v == line_buf.size()) line_buf.push_back(rand_text_byte());
                else line_buf[v] = rand_text_byte();
            end else begin
                // a zero byte ends the command text early
                line_buf.insert(v, CH_NUL);
                repeat ($urandom_range(3)) line_buf.push_back(rand_text_byte());
            end
        end else if (kind < 95) begin
            if ($urandom_range(1)) add_text("ON");
            repeat ($urandom_range(70, 56)) line_buf.push_back(rand_text_byte());
        end else begin
            repeat ($urandom_range(6)) line_buf.push_back(rand_text_byte());
        end
        foreach (line_buf[i]) send_byte(line_buf[i]);
        if (kind < 98) send_byte(CH_BANG);
        if ($urandom_range(39) == 0) drain();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed lines at the reset timer top
        send_text("!");
        send_text("Status!");
        send_text("ON!");
        send_text("Status!");
        send_text("PWM:%!");
        send_text("PWM:100%!");
        send_text("PWM:101%!");
        send_text("PWM:7x%!");
        send_text("PWM:42!");
        send_text("PWM:42%ab!");
        send_text("OFF!");
        send_text("PWM:5%!");
        send_text("O");
        send_byte(8'hFF);
        send_text("N!");
        send_text("ON");
        send_byte(CH_NUL);
        send_byte(8'hFF);
        send_text("!");
        drain();

        write_top(16'hFFFF);
        src_idle  = 24;
        sink_idle = 85;
        while (bytes_sent < 700) random_line();
        drain();

        write_top(16'd1);
        src_idle  = 85;
        sink_idle = 24;
        while (bytes_sent < 1300) random_line();
        drain();

        write_top(16'($urandom_range(65535, 1)));
        src_idle  = 0;
        sink_idle = 0;
        while (bytes_sent < 1900) random_line();
        drain();

        if (tracker.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/ucd_pkg.sv
sv/ucd_parser.sv
sv/ucd_scaler.sv
sv/uart_led_command_decoder.sv
sim/tb.sv
